/* rtl/core/dfa_pkg.sv */
// Package: shared types and command/status codes of the DFA transition table.
package dfa_pkg;

   // Fixed geometry: states fill the 6-bit fields, buckets split the low symbol bits.
   localparam int STATE_COUNT  = 64;
   localparam int HASH_BUCKETS = 16;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_REACHER_FULL = 2'd1;
   localparam logic [1:0] STATUS_BUCKET_FULL  = 2'd2;

   typedef struct packed {
      logic       cmd;
      logic [5:0] source_state;
      logic [7:0] symbol;
      logic [5:0] target_state;
   } req_type;

   typedef struct packed {
      logic [5:0] next_state;
      logic [1:0] status;
   } rsp_type;

   // Request from the sequencer to the reacher-list search unit.
   typedef struct packed {
      logic        start;
      logic [5:0]  tgt;
      logic [13:0] pair;
   } search_req_type;

   // Answer of the reacher-list search unit.
   typedef struct packed {
      logic done;
      logic found;
      logic full;
   } search_rsp_type;

endpackage

/* rtl/core/dfa_if.sv */
// Interfaces: valid/ready channels for requests and responses.
interface dfa_req_if;
   logic               valid;
   logic               ready;
   dfa_pkg::req_type   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface dfa_rsp_if;
   logic               valid;
   logic               ready;
   dfa_pkg::rsp_type   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/dfa_reacher.sv */
// Reacher store: pair memory, per-target counts and a serial search unit.
module dfa_reacher #(
   parameter int REACHER_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dfa_pkg::search_req_type   search_req,
   output dfa_pkg::search_rsp_type   search_rsp,
   input  logic                      append,
   input  logic                      clear,
   input  logic [5:0]                clear_idx
);
   localparam int STATE_COUNT = dfa_pkg::STATE_COUNT;
   localparam int SW = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
   localparam int RW = (REACHER_DEPTH > 1) ? $clog2(REACHER_DEPTH) : 1;
   localparam int CW = $clog2(REACHER_DEPTH + 1);
   localparam int AW = SW + RW;

   logic [13:0]   pair_mem [STATE_COUNT * REACHER_DEPTH];
   logic [CW-1:0] count_mem [STATE_COUNT];

   logic          busy_ff, busy_in;
   logic          wait_ff, wait_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [SW-1:0] tgt_ff, tgt_in;
   logic [13:0]   pair_ff, pair_in;
   logic [13:0]   rdata_ff;
   logic [CW-1:0] cnt_ff;
   logic          done_in, found_in;
   logic          done_ff, found_ff;

   always_comb begin
      busy_in    = busy_ff;
      wait_in    = 1'b0;
      rd_pend_in = 1'b0;
      idx_in     = idx_ff;
      tgt_in     = tgt_ff;
      pair_in    = pair_ff;
      done_in    = 1'b0;
      found_in   = found_ff;
      if (search_req.start) begin
         busy_in  = 1'b1;
         wait_in  = 1'b1;
         idx_in   = '0;
         tgt_in   = search_req.tgt[SW-1:0];
         pair_in  = search_req.pair;
         found_in = 1'b0;
      end else if (busy_ff && !wait_ff) begin
         if (rd_pend_ff) begin
            // compare the word read last cycle
            if (rdata_ff == pair_ff) begin
               found_in = 1'b1;
               busy_in  = 1'b0;
               done_in  = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end else if (idx_ff >= cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rd_pend_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         wait_ff    <= 1'b0;
         rd_pend_ff <= 1'b0;
         done_ff    <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         wait_ff    <= wait_in;
         rd_pend_ff <= rd_pend_in;
         done_ff    <= done_in;
         found_ff   <= found_in;
      end
      idx_ff  <= idx_in;
      tgt_ff  <= tgt_in;
      pair_ff <= pair_in;
   end

   // Pair memory: one write and one read port.
   always_ff @(posedge clock) begin
      if (append)
         pair_mem[AW'(tgt_ff) * AW'(REACHER_DEPTH) + AW'(cnt_ff[RW-1:0])] <= pair_ff;
      rdata_ff <= pair_mem[AW'(tgt_ff) * AW'(REACHER_DEPTH) + AW'(idx_ff[RW-1:0])];
   end

   // Count memory: zeroed by the clearing pass, bumped on append.
   always_ff @(posedge clock) begin
      if (clear) count_mem[clear_idx[SW-1:0]] <= '0;
      else if (append) count_mem[tgt_ff] <= cnt_ff + 1'b1;
      cnt_ff <= count_mem[tgt_ff];
   end

   assign search_rsp.done  = done_ff;
   assign search_rsp.found = found_ff;
   assign search_rsp.full  = (cnt_ff >= CW'(REACHER_DEPTH));
endmodule

/* rtl/core/dfa_transition_table.sv */
// Top level: DFA transition table with bucket memory and sequencer.
//
// Usage: items enter on req (cmd, source_state, symbol, target_state) and
// one response item leaves on rsp (next_state, status) for each of them.
// An add (cmd 0) appends the target to the bucket of (source, symbol mod
// HASH_BUCKETS) and records (source, symbol) once in the target's reacher
// list; status 1 flags a full reacher list, 2 a full bucket.
// A lookup (cmd 1) walks the bucket in insertion order and answers the first
// candidate whose reacher list holds (source, symbol), else root state 0.
// A reacher-list search scans its entries one at a time through the single
// read port of the pair memory; an add waits for one search, a lookup for
// one search per bucket candidate, up to BUCKET_DEPTH of them.
// One item is in flight at a time; req.ready is low until the response is
// taken. A stalled receiver holds the response and the block.
// Reset: synchronous; a clearing pass over all STATE_COUNT*HASH_BUCKETS slots
// then zeroes all fill counts while req.ready stays low.
module dfa_transition_table #(
   parameter int BUCKET_DEPTH  = 8,
   parameter int REACHER_DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   dfa_req_if.sink       req,
   dfa_rsp_if.source     rsp
);
   localparam int SW   = (dfa_pkg::STATE_COUNT > 1) ? $clog2(dfa_pkg::STATE_COUNT) : 1;
   localparam int HW   = (dfa_pkg::HASH_BUCKETS > 1) ? $clog2(dfa_pkg::HASH_BUCKETS) : 1;
   localparam int BW   = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int BCW  = $clog2(BUCKET_DEPTH + 1);
   localparam int SLOTS = dfa_pkg::STATE_COUNT * dfa_pkg::HASH_BUCKETS;
   localparam int SLW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TAW  = SLW + BW;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ASRCH  = 3'd1;
   localparam logic [2:0] ST_LREAD  = 3'd2;
   localparam logic [2:0] ST_LCAND  = 3'd3;
   localparam logic [2:0] ST_LSRCH  = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;
   localparam logic [2:0] ST_AWAIT  = 3'd6;
   localparam logic [2:0] ST_CLEAR  = 3'd7;

   logic [2:0]       state_ff, state_in;
   dfa_pkg::req_type item_ff, item_in;
   logic [5:0]       next_ff, next_in;
   logic [1:0]       status_ff, status_in;
   logic [BCW-1:0]   pos_ff, pos_in;
   logic [SLW-1:0]   clr_ff, clr_in;
   logic             clearing;

   logic [5:0]       tgt_mem [SLOTS * BUCKET_DEPTH];
   logic [BCW-1:0]   bcount_mem [SLOTS];
   logic [BCW-1:0]   bcnt_ff;
   logic [5:0]       cand_ff;

   dfa_pkg::search_req_type sreq;
   dfa_pkg::search_rsp_type srsp;
   logic                    bucket_wr;
   logic                    reacher_wr;

   logic [SW-1:0]  src;
   logic [SLW-1:0] slot;
   logic [13:0]    pair;

   // Hash the symbol into a bucket of the source state.
   assign src  = item_ff.source_state[SW-1:0];
   assign slot = SLW'(src) * SLW'(dfa_pkg::HASH_BUCKETS) + SLW'(item_ff.symbol[HW-1:0]);
   assign pair = {6'(src), item_ff.symbol};

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      next_in    = next_ff;
      status_in  = status_ff;
      pos_in     = pos_ff;
      clr_in     = clr_ff;
      clearing   = 1'b0;
      sreq.start = 1'b0;
      sreq.tgt   = 6'(item_ff.target_state[SW-1:0]);
      sreq.pair  = pair;
      bucket_wr  = 1'b0;
      reacher_wr = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            // zero one bucket count and one reacher count per cycle
            clearing = 1'b1;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == SLW'(SLOTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req.valid) begin
               item_in   = req.data;
               next_in   = '0;
               status_in = dfa_pkg::STATUS_OK;
               pos_in    = '0;
               state_in  = ST_AWAIT;
            end
         end
         ST_AWAIT: begin
            // the bucket count of the new slot is being read; launch the
            // reacher search for an add, move to the bucket walk for a lookup
            if (item_ff.cmd == dfa_pkg::CMD_ADD) begin
               sreq.start = 1'b1;
               state_in   = ST_ASRCH;
            end else begin
               state_in   = ST_LREAD;
            end
         end
         ST_ASRCH: begin
            if (srsp.done) begin
               if (!srsp.found && srsp.full) begin
                  status_in = dfa_pkg::STATUS_REACHER_FULL;
               end else if (bcnt_ff >= BCW'(BUCKET_DEPTH)) begin
                  status_in = dfa_pkg::STATUS_BUCKET_FULL;
               end else begin
                  bucket_wr  = 1'b1;
                  reacher_wr = !srsp.found;
               end
               state_in = ST_RESP;
            end
         end
         ST_LREAD: begin
            // read the next candidate, or give up with root
            if (pos_ff >= bcnt_ff) state_in = ST_RESP;
            else state_in = ST_LCAND;
         end
         ST_LCAND: begin
            sreq.start = 1'b1;
            sreq.tgt   = 6'(cand_ff[SW-1:0]);
            state_in   = ST_LSRCH;
         end
         ST_LSRCH: begin
            if (srsp.done) begin
               if (srsp.found) begin
                  next_in  = 6'(cand_ff[SW-1:0]);
                  state_in = ST_RESP;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = ST_LREAD;
               end
            end
         end
         ST_RESP: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      item_ff   <= item_in;
      next_ff   <= next_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
   end

   // Bucket count memory: cleared after reset, bumped on append.
   always_ff @(posedge clock) begin
      if (clearing) bcount_mem[clr_ff] <= '0;
      else if (bucket_wr) bcount_mem[slot] <= bcnt_ff + 1'b1;
      bcnt_ff <= bcount_mem[slot];
   end

   // Bucket target memory: append on add, read one candidate per step.
   always_ff @(posedge clock) begin
      if (bucket_wr)
         tgt_mem[TAW'(slot) * TAW'(BUCKET_DEPTH) + TAW'(bcnt_ff[BW-1:0])] <=
            item_ff.target_state;
      cand_ff <= tgt_mem[TAW'(slot) * TAW'(BUCKET_DEPTH) + TAW'(pos_ff[BW-1:0])];
   end

   dfa_reacher #(
      .REACHER_DEPTH (REACHER_DEPTH)
   ) u_reacher (
      .clock      (clock),
      .reset      (reset),
      .search_req (sreq),
      .search_rsp (srsp),
      .append     (reacher_wr),
      .clear      (clearing),
      .clear_idx  (clr_ff[SW-1:0])
   );

   assign req.ready           = (state_ff == ST_IDLE);
   assign rsp.valid           = (state_ff == ST_RESP);
   assign rsp.data.next_state = next_ff;
   assign rsp.data.status     = status_ff;
endmodule
